FILE: rtl/tap_and_shake_gesture_detector_unit_assert.svh
// Assertion macros shared by the gesture detector RTL.
`ifndef TAP_AND_SHAKE_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define TAP_AND_SHAKE_GESTURE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tsg_pkg.sv
// Shared constants for the tap and shake gesture detector.
`timescale 1ns / 1ps

package tsg_pkg;

   // csr register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_THRESH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_MAX_LEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAKE_ENTRY = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAKE_QUIET = 3'd6;

   // csr reset values
   localparam logic signed [15:0] RST_BASE_X      = 16'sd224;
   localparam logic signed [15:0] RST_BASE_Y      = 16'sd66;
   localparam logic signed [15:0] RST_BASE_Z      = 16'sd16138;
   localparam logic [15:0]        RST_TAP_THRESH  = 16'd5734;
   localparam logic [7:0]         RST_TAP_MAX_LEN = 8'd3;
   localparam logic [15:0]        RST_SHAKE_ENTRY = 16'd1229;
   localparam logic [15:0]        RST_SHAKE_QUIET = 16'd573;

   // event codes on the result channel
   typedef logic [1:0] event_type;
   localparam event_type EV_NONE        = 2'd0;
   localparam event_type EV_TAP         = 2'd1;
   localparam event_type EV_SHAKE_START = 2'd2;
   localparam event_type EV_SHAKE_END   = 2'd3;

   // shake machine defaults
   localparam int WINDOW_LEN_DEF = 25;
   localparam int MAX_QUIET_DEF  = 10;
   localparam int EXIT_QUIET_DEF = 25;

endpackage

FILE: rtl/tap_and_shake_gesture_detector_unit.sv
// Tap and shake gesture detector: three-stage sample pipeline with csr block.
// A sample accepted on req passes the stage 1, stage 2 and result registers before its beat is valid.
// Throughput: one sample per cycle; the output register stalls the whole pipe.
// Stage 1 takes differences, stage 2 the three squares, stage 3 the tap/shake update.
// Reset (synchronous, active high) clears pipe valids and gesture state, loads csr
// reset values, and holds both ready outputs low.
`timescale 1ns / 1ps

module tap_and_shake_gesture_detector_unit #(
   parameter int WINDOW_LEN = tsg_pkg::WINDOW_LEN_DEF,
   parameter int MAX_QUIET  = tsg_pkg::MAX_QUIET_DEF,
   parameter int EXIT_QUIET = tsg_pkg::EXIT_QUIET_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // sample channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_accel_x,
   input  logic signed [15:0]             req_accel_y,
   input  logic signed [15:0]             req_accel_z,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tsg_pkg::event_type             rsp_event_code,
   output logic                           rsp_shaking,
   // csr write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_data
);

   localparam int QC_MAX = (MAX_QUIET > WINDOW_LEN) ? MAX_QUIET : WINDOW_LEN;
   localparam int WIN_W  = $clog2(WINDOW_LEN + 1);
   localparam int QC_W   = $clog2(QC_MAX + 1);
   localparam int RUN_W  = $clog2(EXIT_QUIET + 1);
   localparam logic [WIN_W-1:0] WIN_END = WIN_W'(WINDOW_LEN);
   localparam logic [QC_W-1:0]  QC_LIM  = QC_W'(MAX_QUIET);
   localparam logic [RUN_W-1:0] RUN_END = RUN_W'(EXIT_QUIET);

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_DETECT = 2'd1;
   localparam logic [1:0] MODE_SHAKE  = 2'd2;

   // csr registers
   logic signed [15:0] base_x_ff, base_y_ff, base_z_ff;
   logic [15:0]        tap_thresh_ff, shake_entry_ff, shake_quiet_ff;
   logic [7:0]         tap_max_len_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff      <= tsg_pkg::RST_BASE_X;
         base_y_ff      <= tsg_pkg::RST_BASE_Y;
         base_z_ff      <= tsg_pkg::RST_BASE_Z;
         tap_thresh_ff  <= tsg_pkg::RST_TAP_THRESH;
         tap_max_len_ff <= tsg_pkg::RST_TAP_MAX_LEN;
         shake_entry_ff <= tsg_pkg::RST_SHAKE_ENTRY;
         shake_quiet_ff <= tsg_pkg::RST_SHAKE_QUIET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tsg_pkg::CSR_BASE_X:      base_x_ff      <= csr_data;
            tsg_pkg::CSR_BASE_Y:      base_y_ff      <= csr_data;
            tsg_pkg::CSR_BASE_Z:      base_z_ff      <= csr_data;
            tsg_pkg::CSR_TAP_THRESH:  tap_thresh_ff  <= csr_data;
            tsg_pkg::CSR_TAP_MAX_LEN: tap_max_len_ff <= csr_data[7:0];
            tsg_pkg::CSR_SHAKE_ENTRY: shake_entry_ff <= csr_data;
            tsg_pkg::CSR_SHAKE_QUIET: shake_quiet_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipe advances unless a result beat is stuck at the output
   logic en;
   logic v1_ff, v2_ff, rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // stage 1: baseline differences and x deviation
   logic signed [16:0] dx_in, dy_in, dz_in, dx_ff, dy_ff, dz_ff;
   logic [16:0]        ax;
   logic signed [17:0] dev;
   logic [16:0]        d_in, d_ff;

   always_comb begin
      dx_in = 17'(req_accel_x) - 17'(base_x_ff);
      dy_in = 17'(req_accel_y) - 17'(base_y_ff);
      dz_in = 17'(req_accel_z) - 17'(base_z_ff);
      ax    = req_accel_x[15] ? (17'd0 - 17'(req_accel_x)) : 17'(req_accel_x);
      dev   = $signed({1'b0, ax}) - 18'(base_x_ff);
      d_in  = dev[17] ? 17'd0 : dev[16:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         d_ff  <= d_in;
      end
   end

   // stage 2: squares, threshold square, shake level compares
   logic signed [33:0] sqx_full, sqy_full, sqz_full;
   logic [31:0]        sqx_ff, sqy_ff, sqz_ff, thr2_in, thr2_ff;
   logic               quiet_in, quiet_ff, entry_in, entry_ff;

   always_comb begin
      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
      sqz_full = dz_ff * dz_ff;
      thr2_in  = tap_thresh_ff * tap_thresh_ff;
      quiet_in = d_ff < {1'b0, shake_quiet_ff};
      entry_in = d_ff > {1'b0, shake_entry_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= sqx_full[31:0];
         sqy_ff   <= sqy_full[31:0];
         sqz_ff   <= sqz_full[31:0];
         thr2_ff  <= thr2_in;
         quiet_ff <= quiet_in;
         entry_ff <= entry_in;
      end
   end

   // stage 3: gesture state
   logic             in_spike_ff, in_spike_in;
   logic [7:0]       spike_len_ff, spike_len_in, spike_base;
   logic [1:0]       mode_ff, mode_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [QC_W-1:0]  quiet_cnt_ff, quiet_cnt_in;
   logic [RUN_W-1:0] quiet_run_ff, quiet_run_in;
   logic [33:0]      dist2;
   logic             spike;
   tsg_pkg::event_type event_in, rsp_event_ff;
   logic             rsp_shaking_ff;

   always_comb begin
      dist2 = {2'b00, sqx_ff} + {2'b00, sqy_ff} + {2'b00, sqz_ff};
      spike = dist2 >= {2'b00, thr2_ff};

      in_spike_in  = in_spike_ff;
      spike_len_in = spike_len_ff;
      mode_in      = mode_ff;
      window_in    = window_ff;
      quiet_cnt_in = quiet_cnt_ff;
      quiet_run_in = quiet_run_ff;
      event_in     = tsg_pkg::EV_NONE;
      spike_base   = in_spike_ff ? spike_len_ff : 8'd0;

      // tap: a spike run that ends short enough reports a tap
      if (spike) begin
         in_spike_in  = 1'b1;
         spike_len_in = (spike_base != 8'hFF) ? spike_base + 8'd1 : spike_base;
      end else if (in_spike_ff) begin
         in_spike_in = 1'b0;
         if (spike_len_ff <= tap_max_len_ff) begin
            event_in = tsg_pkg::EV_TAP;
         end
      end

      // shake machine; its events override a tap
      unique case (mode_ff)
         MODE_DETECT: begin
            window_in = window_ff + WIN_W'(1);
            if (quiet_ff) begin
               quiet_cnt_in = quiet_cnt_ff + QC_W'(1);
            end
            if (window_in >= WIN_END) begin
               if (quiet_cnt_in < QC_LIM) begin
                  mode_in      = MODE_SHAKE;
                  quiet_run_in = '0;
                  event_in     = tsg_pkg::EV_SHAKE_START;
               end else begin
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_SHAKE: begin
            if (quiet_ff) begin
               quiet_run_in = quiet_run_ff + RUN_W'(1);
               if (quiet_run_in >= RUN_END) begin
                  mode_in  = MODE_IDLE;
                  event_in = tsg_pkg::EV_SHAKE_END;
               end
            end else begin
               quiet_run_in = '0;
            end
         end
         default: begin
            // idle, and the unused code behaves as idle
            mode_in = MODE_IDLE;
            if (entry_ff) begin
               mode_in      = MODE_DETECT;
               window_in    = '0;
               quiet_cnt_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_spike_ff  <= 1'b0;
         spike_len_ff <= 8'd0;
         mode_ff      <= MODE_IDLE;
         window_ff    <= '0;
         quiet_cnt_ff <= '0;
         quiet_run_ff <= '0;
      end else if (en && v2_ff) begin
         in_spike_ff  <= in_spike_in;
         spike_len_ff <= spike_len_in;
         mode_ff      <= mode_in;
         window_ff    <= window_in;
         quiet_cnt_ff <= quiet_cnt_in;
         quiet_run_ff <= quiet_run_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_event_ff   <= event_in;
         rsp_shaking_ff <= (mode_in == MODE_SHAKE);
      end
   end

   assign rsp_event_code = rsp_event_ff;
   assign rsp_shaking    = rsp_shaking_ff;

`include "tap_and_shake_gesture_detector_unit_assert.svh"

   `TSG_ASSERT_SAME(a_start_shaking, clock, reset,
      rsp_valid_ff && (rsp_event_ff == tsg_pkg::EV_SHAKE_START), rsp_shaking_ff,
      "shake start beat without shaking flag")
   `TSG_ASSERT_SAME(a_end_idle, clock, reset,
      rsp_valid_ff && (rsp_event_ff == tsg_pkg::EV_SHAKE_END), !rsp_shaking_ff,
      "shake end beat with shaking flag set")
   `TSG_ASSERT_NEXT(a_stall_holds_state, clock, reset,
      v2_ff && !en, $stable(mode_ff) && $stable(spike_len_ff) && $stable(quiet_run_ff),
      "gesture state moved while output stalled")
   `TSG_ASSERT_SAME(a_spike_len_nonzero, clock, reset,
      in_spike_ff, spike_len_ff != 8'd0,
      "spike run active with zero length")

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the tap and shake gesture detector unit.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 16;
   // index past the last register, writes to it are dropped
   localparam logic [tsg_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum logic [1:0] {SHK_IDLE, SHK_DETECT, SHK_SHAKING} shake_state_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } sample_type;

   typedef struct {
      tsg_pkg::event_type code;
      logic               shaking;
   } gesture_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [15:0]            req_accel_x = '0;
   logic signed [15:0]            req_accel_y = '0;
   logic signed [15:0]            req_accel_z = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   tsg_pkg::event_type            rsp_event_code;
   logic                          rsp_shaking;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tsg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]                   csr_data = '0;

   // stimulus and expectation stores
   sample_type  sample_q[$];
   gesture_type gesture_q[$];

   // idling knobs and bookkeeping
   int src_gap_pct = 36;
   int rcv_gap_pct = 59;
   int hold_at = 32'h7fffffff;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int samples_taken = 0;
   int beats_checked = 0;
   int csr_writes = 0;
   int fail_cnt = 0;
   int cycle_cnt = 0;
   int event_seen[4] = '{default: 0};

   // register copies
   logic signed [15:0] cfg_base_x = tsg_pkg::RST_BASE_X;
   logic signed [15:0] cfg_base_y = tsg_pkg::RST_BASE_Y;
   logic signed [15:0] cfg_base_z = tsg_pkg::RST_BASE_Z;
   logic [15:0]        cfg_tap_thresh = tsg_pkg::RST_TAP_THRESH;
   logic [7:0]         cfg_tap_max_len = tsg_pkg::RST_TAP_MAX_LEN;
   logic [15:0]        cfg_shake_entry = tsg_pkg::RST_SHAKE_ENTRY;
   logic [15:0]        cfg_shake_quiet = tsg_pkg::RST_SHAKE_QUIET;

   // gesture state copies
   bit              in_spike = 1'b0;
   int              spike_len = 0;
   shake_state_type shake_state = SHK_IDLE;
   int              window_cnt = 0;
   int              quiet_cnt = 0;
   int              quiet_run = 0;

   tap_and_shake_gesture_detector_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .rsp_shaking    (rsp_shaking),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // tap and shake update for one sample, advances the state copies
   function automatic gesture_type predict_gesture(logic signed [15:0] sx,
                                                   logic signed [15:0] sy,
                                                   logic signed [15:0] sz);
      gesture_type g;
      longint      dx, dy, dz, dist2, thr2;
      int          xi, mag, dev, entry, quiet_lvl;
      bit          quiet;
      g.code = tsg_pkg::EV_NONE;
      dx = longint'(sx) - longint'(cfg_base_x);
      dy = longint'(sy) - longint'(cfg_base_y);
      dz = longint'(sz) - longint'(cfg_base_z);
      dist2 = dx * dx + dy * dy + dz * dz;
      thr2 = longint'(cfg_tap_thresh) * longint'(cfg_tap_thresh);
      // tap: spike run that ends within the allowed length
      if (dist2 >= thr2) begin
         if (!in_spike) begin
            in_spike = 1'b1;
            spike_len = 0;
         end
         if (spike_len < 255)
            spike_len++;
      end else if (in_spike) begin
         in_spike = 1'b0;
         if (spike_len <= int'(cfg_tap_max_len))
            g.code = tsg_pkg::EV_TAP;
      end
      // shake: x deviation above baseline, clamped at zero
      xi = sx;
      mag = (xi < 0) ? -xi : xi;
      dev = mag - int'(cfg_base_x);
      if (dev < 0)
         dev = 0;
      entry = cfg_shake_entry;
      quiet_lvl = cfg_shake_quiet;
      quiet = (dev < quiet_lvl);
      case (shake_state)
         SHK_DETECT: begin
            window_cnt++;
            if (quiet)
               quiet_cnt++;
            if (window_cnt >= tsg_pkg::WINDOW_LEN_DEF) begin
               if (quiet_cnt < tsg_pkg::MAX_QUIET_DEF) begin
                  shake_state = SHK_SHAKING;
                  quiet_run = 0;
                  g.code = tsg_pkg::EV_SHAKE_START;
               end else begin
                  shake_state = SHK_IDLE;
               end
            end
         end
         SHK_SHAKING: begin
            if (quiet) begin
               quiet_run++;
               if (quiet_run >= tsg_pkg::EXIT_QUIET_DEF) begin
                  shake_state = SHK_IDLE;
                  g.code = tsg_pkg::EV_SHAKE_END;
               end
            end else begin
               quiet_run = 0;
            end
         end
         default: begin
            shake_state = SHK_IDLE;
            if (dev > entry) begin
               shake_state = SHK_DETECT;
               window_cnt = 0;
               quiet_cnt = 0;
            end
         end
      endcase
      g.shaking = (shake_state == SHK_SHAKING);
      return g;
   endfunction

   function automatic logic signed [15:0] sat16(int v);
      if (v > 32767)
         return 16'sd32767;
      if (v < -32768)
         return -16'sd32768;
      return 16'(v);
   endfunction

   task automatic push_sample(int x, int y, int z);
      sample_type s;
      s.x = sat16(x);
      s.y = sat16(y);
      s.z = sat16(z);
      sample_q.push_back(s);
   endtask

   // baseline plus a little noise on every axis
   task automatic push_rest();
      push_sample(int'(cfg_base_x) + $urandom_range(0, 200) - 100,
                  int'(cfg_base_y) + $urandom_range(0, 200) - 100,
                  int'(cfg_base_z) + $urandom_range(0, 200) - 100);
   endtask

   // x far enough out to count as shake activity
   function automatic int loud_x();
      int mag;
      mag = int'(cfg_base_x) + int'(cfg_shake_entry) + 1 + $urandom_range(0, 4000);
      if (mag > 32768)
         mag = 32768;
      if (mag < 0)
         mag = 0;
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // x close enough in to count as a quiet sample, where that is possible
   function automatic int calm_x();
      int lim, mag;
      lim = int'(cfg_base_x) + int'(cfg_shake_quiet) - 1;
      if (lim < 0)
         return 0;
      if (lim > 32767)
         lim = 32767;
      mag = $urandom_range(0, lim);
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // queue n or a few more samples built from gesture episodes and noise
   task automatic fill_phase(int n);
      int target, kind, len, qpct, lim, sgn, i;
      target = sample_q.size() + n;
      while (sample_q.size() < target) begin
         kind = $urandom_range(99);
         if (kind < 15) begin
            // raw noise over the full range
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
               push_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                           $urandom_range(0, 65535) - 32768);
         end else if (kind < 40) begin
            // spike run on z, then back to rest
            lim = int'(cfg_tap_max_len) + 2;
            if (lim > 12)
               lim = 12;
            len = $urandom_range(1, lim);
            for (i = 0; i < len; i++) begin
               sgn = $urandom_range(1) ? -1 : 1;
               push_sample(int'(cfg_base_x), int'(cfg_base_y), int'(cfg_base_z)
                           + sgn * (int'(cfg_tap_thresh) + $urandom_range(0, 3000)));
            end
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++)
               push_rest();
         end else if (kind < 70) begin
            // entry, detection window with some quiet samples, quiet tail
            push_sample(loud_x(), int'(cfg_base_y), int'(cfg_base_z));
            qpct = $urandom_range(0, 60);
            len = $urandom_range(24, 27);
            for (i = 0; i < len; i++)
               push_sample(($urandom_range(99) < qpct) ? calm_x() : loud_x(),
                           int'(cfg_base_y) + $urandom_range(0, 400) - 200,
                           int'(cfg_base_z) + $urandom_range(0, 400) - 200);
            len = $urandom_range(20, 32);
            for (i = 0; i < len; i++) begin
               if (i == len / 2 && $urandom_range(3) == 0)
                  push_sample(loud_x(), int'(cfg_base_y), int'(cfg_base_z));
               else
                  push_sample(calm_x(), int'(cfg_base_y), int'(cfg_base_z));
            end
         end else begin
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++)
               push_rest();
         end
      end
      // close each phase at the exact baseline
      push_sample(int'(cfg_base_x), int'(cfg_base_y), int'(cfg_base_z));
      push_sample(int'(cfg_base_x), int'(cfg_base_y), int'(cfg_base_z));
   endtask

   task automatic csr_write(logic [tsg_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         tsg_pkg::CSR_BASE_X:      cfg_base_x = val;
         tsg_pkg::CSR_BASE_Y:      cfg_base_y = val;
         tsg_pkg::CSR_BASE_Z:      cfg_base_z = val;
         tsg_pkg::CSR_TAP_THRESH:  cfg_tap_thresh = val;
         tsg_pkg::CSR_TAP_MAX_LEN: cfg_tap_max_len = val[7:0];
         tsg_pkg::CSR_SHAKE_ENTRY: cfg_shake_entry = val;
         tsg_pkg::CSR_SHAKE_QUIET: cfg_shake_quiet = val;
         default: ;
      endcase
   endtask

   // wait until every queued sample is in and every result is out
   task automatic settle();
      @(negedge clock);
      while (sample_q.size() != 0 || req_valid || gesture_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_gaps(int src_pct, int rcv_pct);
      @(negedge clock);
      src_gap_pct = src_pct;
      rcv_gap_pct = rcv_pct;
   endtask

   // sample driver
   always @(posedge clock) begin : sample_driver
      sample_type nxt;
      logic       take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && req_ready;
         if (take) begin
            gesture_q.push_back(predict_gesture(req_accel_x, req_accel_y, req_accel_z));
            samples_taken <= samples_taken + 1;
         end
         if (!req_valid || take) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
               nxt = sample_q.pop_front();
               req_valid <= 1'b1;
               req_accel_x <= nxt.x;
               req_accel_y <= nxt.y;
               req_accel_z <= nxt.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : result_monitor
      gesture_type want;
      logic        rdy;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            event_seen[rsp_event_code]++;
            if (gesture_q.size() == 0) begin
               $error("result beat with no sample outstanding");
               fail_cnt++;
            end else begin
               want = gesture_q.pop_front();
               if (rsp_event_code !== want.code) begin
                  $error("event_code: expected %0d, actual %0d", want.code, rsp_event_code);
                  fail_cnt++;
               end
               if (rsp_shaking !== want.shaking) begin
                  $error("shaking: expected %0d, actual %0d", want.shaking, rsp_shaking);
                  fail_cnt++;
               end
            end
         end
         // one long hold-off lets the pipe fill up and back-pressure the input
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rdy = 1'b0;
         end else if (!hold_done && samples_taken >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rdy = 1'b0;
         end else begin
            rdy = ($urandom_range(99) >= rcv_gap_pct);
         end
         rsp_ready <= rdy;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (7)
         @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, tap run lengths, threshold edge
      @(negedge clock);
      push_sample(224, 66, 16138);
      push_sample(32767, 32767, 32767);
      push_sample(224, 66, 16138);
      push_sample(-32768, -32768, -32768);
      push_sample(-32768, -32768, -32768);
      push_sample(224, 66, 16138);
      push_sample(0, 0, 0);
      push_sample(-1, -1, -1);
      push_sample(1, 1, 1);
      push_sample(0, 0, 0);
      push_sample(224, 66, 16138);
      push_sample(224, 66, 16138 + 5734);
      push_sample(224, 66, 16138 - 5734);
      push_sample(224, 66, 16138 + 5734);
      push_sample(224, 66, 16138 - 5733);
      push_sample(224 + 1229, 66, 16138);
      push_sample(-(224 + 1230), 66, 16138);
      push_sample(224 + 572, 66, 16138);
      push_sample(224 + 573, 66, 16138);
      push_sample(21845, -21846, 21845);
      push_sample(224, 66, 16138);

      // reset values, sender and receiver both idle often
      settle();
      fill_phase(400);

      settle();
      csr_write(tsg_pkg::CSR_BASE_X, 16'd0);
      csr_write(tsg_pkg::CSR_BASE_Y, 16'd0);
      csr_write(tsg_pkg::CSR_BASE_Z, 16'd8192);
      csr_write(tsg_pkg::CSR_TAP_THRESH, 16'd3000);
      csr_write(tsg_pkg::CSR_TAP_MAX_LEN, 16'd1);
      csr_write(tsg_pkg::CSR_SHAKE_ENTRY, 16'd2000);
      csr_write(tsg_pkg::CSR_SHAKE_QUIET, 16'd800);
      fill_phase(300);

      // register extremes, plus a write to an unused index
      settle();
      csr_write(tsg_pkg::CSR_BASE_X, 16'h8000);
      csr_write(tsg_pkg::CSR_BASE_Y, 16'h7fff);
      csr_write(tsg_pkg::CSR_BASE_Z, 16'h8000);
      csr_write(tsg_pkg::CSR_TAP_THRESH, 16'hffff);
      csr_write(tsg_pkg::CSR_TAP_MAX_LEN, 16'd254);
      csr_write(tsg_pkg::CSR_SHAKE_ENTRY, 16'h0000);
      csr_write(tsg_pkg::CSR_SHAKE_QUIET, 16'h8000);
      csr_write(CSR_UNUSED, 16'ha5a5);
      set_gaps(59, 36);
      fill_phase(200);

      // zero threshold: every sample is a spike, the run length saturates
      settle();
      csr_write(tsg_pkg::CSR_BASE_X, tsg_pkg::RST_BASE_X);
      csr_write(tsg_pkg::CSR_BASE_Y, tsg_pkg::RST_BASE_Y);
      csr_write(tsg_pkg::CSR_BASE_Z, tsg_pkg::RST_BASE_Z);
      csr_write(tsg_pkg::CSR_TAP_THRESH, 16'd0);
      csr_write(tsg_pkg::CSR_TAP_MAX_LEN, 16'd10);
      csr_write(tsg_pkg::CSR_SHAKE_ENTRY, tsg_pkg::RST_SHAKE_ENTRY);
      csr_write(tsg_pkg::CSR_SHAKE_QUIET, tsg_pkg::RST_SHAKE_QUIET);
      fill_phase(260);

      // long run ends here; largest x baseline, everything counts as quiet
      settle();
      csr_write(tsg_pkg::CSR_TAP_THRESH, 16'd4000);
      csr_write(tsg_pkg::CSR_BASE_X, 16'h7fff);
      csr_write(tsg_pkg::CSR_SHAKE_ENTRY, 16'd0);
      csr_write(tsg_pkg::CSR_SHAKE_QUIET, 16'hffff);
      fill_phase(150);

      // no idling, one long receiver hold-off partway through
      settle();
      csr_write(tsg_pkg::CSR_BASE_X, 16'd100);
      csr_write(tsg_pkg::CSR_BASE_Y, 16'(-100));
      csr_write(tsg_pkg::CSR_BASE_Z, 16'd8000);
      csr_write(tsg_pkg::CSR_TAP_THRESH, 16'd2500);
      csr_write(tsg_pkg::CSR_TAP_MAX_LEN, 16'hff04);
      csr_write(tsg_pkg::CSR_SHAKE_ENTRY, 16'd1500);
      csr_write(tsg_pkg::CSR_SHAKE_QUIET, 16'd600);
      set_gaps(0, 0);
      hold_at = samples_taken + 100;
      fill_phase(350);

      // zero tap length, shake entry out of reach, nothing quiet
      settle();
      csr_write(tsg_pkg::CSR_TAP_THRESH, 16'd6000);
      csr_write(tsg_pkg::CSR_TAP_MAX_LEN, 16'd0);
      csr_write(tsg_pkg::CSR_SHAKE_ENTRY, 16'hffff);
      csr_write(tsg_pkg::CSR_SHAKE_QUIET, 16'd0);
      fill_phase(100);

      settle();
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      $display("covered %0d samples and %0d result beats under %0d register writes",
               samples_taken, beats_checked, csr_writes);
      $display("events seen: %0d none, %0d tap, %0d shake start, %0d shake end",
               event_seen[tsg_pkg::EV_NONE], event_seen[tsg_pkg::EV_TAP],
               event_seen[tsg_pkg::EV_SHAKE_START], event_seen[tsg_pkg::EV_SHAKE_END]);
      if (fail_cnt == 0 && gesture_q.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/tsg_pkg.sv
rtl/tap_and_shake_gesture_detector_unit.sv
tb/sv/tb.sv
